// ----- rtl/cdq_pkg.sv -----
// cdq_pkg: types, operation and status codes for the circular deque.
// Used by cdq_cell and circular_deque_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int WORD_W    = 32;
	localparam int LEVEL_W   = 4;
	localparam int OP_W      = 3;
	localparam int ST_W      = 2;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic signed [WORD_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		logic [ST_W-1:0]          status;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] rear_value;
		logic                     is_full;
		logic                     is_empty;
		logic [LEVEL_W-1:0]       level;
	} rsp_t;

	// Shift/update command broadcast to every cell; already gated by full/empty.
	typedef struct packed {
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_rear;
	} ctl_t;

endpackage

`default_nettype wire

// ----- rtl/circular_deque_top.sv -----
// circular_deque_top: double-ended queue built as a row of DEPTH shifting cells.
// Depends on cdq_pkg and cdq_cell.
`timescale 1ns / 1ps
`default_nettype none

// A transaction is taken at a rising edge with start high and busy low. The
// front word always sits in the first cell and the words shift one cell along
// the row on a front push or front pop; a rear push or pop touches only the
// cell at the rear boundary. The cells update when the transaction is taken;
// pend_q (busy) is then set, and while it is high the front/rear words are read
// back from the row and registered into result_q. The result then shows on
// result for exactly one cycle with done high; it cannot be held off, so capture it on that cycle.
// busy is high between accept and result; a new transaction
// may be started in the cycle that done is high. Pushes when full and pops when
// empty change nothing and report a status code. After reset the deque is empty.
module circular_deque_top #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire cdq_pkg::req_t request,
	output logic               done,
	output cdq_pkg::rsp_t      result
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [cdq_pkg::WORD_W-1:0] cell_word [DEPTH];
	logic                       cell_valid [DEPTH];
	logic                       cell_rear [DEPTH];

	logic [CNT_W-1:0]           count_q;
	logic                       pend_q;
	logic                       done_q;
	logic [cdq_pkg::WORD_W-1:0] popped_s1;
	logic [cdq_pkg::ST_W-1:0]   status_s1;
	cdq_pkg::rsp_t              result_q;

	logic                       accept;
	logic                       full;
	logic                       empty;
	cdq_pkg::ctl_t              ctl;
	logic [cdq_pkg::ST_W-1:0]   status_d;
	logic [cdq_pkg::WORD_W-1:0] rear_word;
	logic [CNT_W+cdq_pkg::LEVEL_W-1:0] level_ext;

	assign accept = start & ~busy;
	assign busy   = pend_q;
	assign done   = done_q;
	assign result = result_q;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	always_comb begin
		ctl      = '0;
		status_d = cdq_pkg::ST_DONE;
		unique case (request.operation)
			cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
				if (full) begin
					status_d = cdq_pkg::ST_FULL;
				end else begin
					ctl.push_front = accept && (request.operation == cdq_pkg::OP_PUSH_FRONT);
					ctl.push_rear  = accept && (request.operation == cdq_pkg::OP_PUSH_REAR);
				end
			end
			cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: begin
				if (empty) begin
					status_d = cdq_pkg::ST_EMPTY;
				end else begin
					ctl.pop_front = accept && (request.operation == cdq_pkg::OP_POP_FRONT);
					ctl.pop_rear  = accept && (request.operation == cdq_pkg::OP_POP_REAR);
				end
			end
			default: begin
				status_d = cdq_pkg::ST_DONE;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [cdq_pkg::WORD_W-1:0] lw;
		logic                       lv;
		logic [cdq_pkg::WORD_W-1:0] rw;
		logic                       rv;

		if (i == 0) begin : g_first
			assign lw = request.data_in;
			assign lv = 1'b1;
		end else begin : g_mid_l
			assign lw = cell_word[i-1];
			assign lv = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rw = '0;
			assign rv = 1'b0;
		end else begin : g_mid_r
			assign rw = cell_word[i+1];
			assign rv = cell_valid[i+1];
		end

		cdq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.push_word   (request.data_in),
			.left_word   (lw),
			.left_valid  (lv),
			.right_word  (rw),
			.right_valid (rv),
			.word        (cell_word[i]),
			.valid       (cell_valid[i]),
			.is_rear     (cell_rear[i])
		);
	end

	// Exactly one cell flags itself as rear when non-empty; none when empty.
	always_comb begin
		rear_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_word = rear_word | (cell_rear[i] ? cell_word[i] : '0);
		end
	end

	assign level_ext = {{cdq_pkg::LEVEL_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			pend_q <= accept;
			done_q <= pend_q;
			if (ctl.push_front || ctl.push_rear) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.pop_front || ctl.pop_rear) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			if (ctl.pop_front) begin
				popped_s1 <= cell_word[0];
			end else if (ctl.pop_rear) begin
				popped_s1 <= rear_word;
			end else begin
				popped_s1 <= '0;
			end
		end
		if (pend_q) begin
			result_q.popped_value <= popped_s1;
			result_q.status       <= status_s1;
			result_q.front_value  <= cell_valid[0] ? cell_word[0] : '0;
			result_q.rear_value   <= rear_word;
			result_q.is_full      <= full;
			result_q.is_empty     <= empty;
			result_q.level        <= level_ext[cdq_pkg::LEVEL_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/cdq_cell.sv -----
// cdq_cell: one storage cell of the deque row (word plus occupied flag).
// Depends on cdq_pkg for the control struct and word width.
`timescale 1ns / 1ps
`default_nettype none

module cdq_cell (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire cdq_pkg::ctl_t                    ctl,
	input  wire logic [cdq_pkg::WORD_W-1:0]       push_word,
	input  wire logic [cdq_pkg::WORD_W-1:0]       left_word,
	input  wire logic                             left_valid,
	input  wire logic [cdq_pkg::WORD_W-1:0]       right_word,
	input  wire logic                             right_valid,
	output logic [cdq_pkg::WORD_W-1:0]            word,
	output logic                                  valid,
	output logic                                  is_rear
);

	logic [cdq_pkg::WORD_W-1:0] word_q;
	logic                       valid_q;

	assign word    = word_q;
	assign valid   = valid_q;
	assign is_rear = valid_q & ~right_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.push_front) begin
			valid_q <= left_valid;
		end else if (ctl.push_rear) begin
			if (!valid_q && left_valid) valid_q <= 1'b1;
		end else if (ctl.pop_front) begin
			valid_q <= right_valid;
		end else if (ctl.pop_rear) begin
			if (valid_q && !right_valid) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			word_q <= left_word;
		end else if (ctl.push_rear) begin
			if (!valid_q && left_valid) word_q <= push_word;
		end else if (ctl.pop_front) begin
			word_q <= right_word;
		end
	end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// tb: self-checking testbench for circular_deque_top with a deque scoreboard class.
// Depends on cdq_pkg and circular_deque_top; stimulus is directed, then random.
`timescale 1ns / 1ps

import cdq_pkg::*;

class deque_scoreboard;
	logic signed [WORD_W-1:0] slots [DEPTH_DEF];
	int head;
	int tail;
	int fill;
	rsp_t snapshots_due [$];
	int mismatches;

	function void note_request(req_t r);
		snapshots_due.push_back(apply_op(r));
	endfunction

	// Deque state after one transaction, as the block should report it.
	function rsp_t apply_op(req_t r);
		rsp_t o;
		logic was_full;
		logic was_empty;
		o = '0;
		o.status = ST_DONE;
		was_full = (fill == DEPTH_DEF);
		was_empty = (fill == 0);
		case (r.operation)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (was_full) begin
					o.status = ST_FULL;
				end else if (was_empty) begin
					head = 0;
					tail = 0;
					slots[0] = r.data_in;
					fill = 1;
				end else if (r.operation == OP_PUSH_FRONT) begin
					head = (head == 0) ? DEPTH_DEF - 1 : head - 1;
					slots[head] = r.data_in;
					fill++;
				end else begin
					tail = (tail == DEPTH_DEF - 1) ? 0 : tail + 1;
					slots[tail] = r.data_in;
					fill++;
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (was_empty) begin
					o.status = ST_EMPTY;
				end else if (r.operation == OP_POP_FRONT) begin
					o.popped_value = slots[head];
					head = (head == DEPTH_DEF - 1) ? 0 : head + 1;
					fill--;
				end else begin
					o.popped_value = slots[tail];
					tail = (tail == 0) ? DEPTH_DEF - 1 : tail - 1;
					fill--;
				end
				if (fill == 0) begin
					head = 0;
					tail = 0;
				end
			end
			default: ; // query and unused codes leave the state alone
		endcase
		o.front_value = (fill == 0) ? '0 : slots[head];
		o.rear_value = (fill == 0) ? '0 : slots[tail];
		o.is_full = (fill == DEPTH_DEF);
		o.is_empty = (fill == 0);
		o.level = fill[LEVEL_W-1:0];
		return o;
	endfunction

	function void field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	function void check_result(rsp_t got);
		rsp_t want;
		if (snapshots_due.size() == 0) begin
			mismatches++;
			$display("%0t: result with no transaction outstanding, actual %0h", $time, got);
			return;
		end
		want = snapshots_due.pop_front();
		field("popped_value", want.popped_value, got.popped_value);
		field("status", WORD_W'(want.status), WORD_W'(got.status));
		field("front_value", want.front_value, got.front_value);
		field("rear_value", want.rear_value, got.rear_value);
		field("is_full", WORD_W'(want.is_full), WORD_W'(got.is_full));
		field("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
		field("level", WORD_W'(want.level), WORD_W'(got.level));
	endfunction
endclass

module tb;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 450;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic done;
	rsp_t result;
	int cycles = 0;
	deque_scoreboard sb;

	circular_deque_top #(.DEPTH(DEPTH_DEF)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("circular_deque_top test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// Drop start for the idle gap given by gap, then hold the transaction until busy is low at an edge.
	task automatic issue(logic [OP_W-1:0] op, logic [WORD_W-1:0] word, int gap);
		req_t r;
		r.operation = op;
		r.data_in = word;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		sb.note_request(r);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 19))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_gap(int idx);
		int roll;
		roll = $urandom_range(0, 99);
		if ((idx % 90) < 25 || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	initial begin
		int push_pct;
		int run_left;
		int roll;
		logic [OP_W-1:0] op;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty deque: a query, then both pops rejected
		issue(OP_QUERY, 32'h1234_5678, 0);
		issue(OP_POP_FRONT, 32'hFFFF_FFFF, 0);
		issue(OP_POP_REAR, 32'h0, 1);
		// push into empty, pop the last word, push into empty again
		issue(OP_PUSH_FRONT, 32'h8000_0000, 0);
		issue(OP_POP_REAR, 32'h0, 0);
		issue(OP_PUSH_REAR, 32'h7FFF_FFFF, 0);
		// front pushes wrap the head below slot 0
		issue(OP_PUSH_FRONT, 32'hFFFF_FFFF, 0);
		issue(OP_PUSH_FRONT, 32'h0, 2);
		issue(OP_PUSH_REAR, 32'h5555_5555, 0);
		issue(OP_PUSH_REAR, 32'hAAAA_AAAA, 0);
		issue(OP_PUSH_FRONT, 32'h1, 0);
		issue(OP_PUSH_REAR, 32'h2, 0);
		issue(OP_PUSH_FRONT, 32'h3, 0);
		// full: both pushes rejected
		issue(OP_PUSH_FRONT, 32'h4, 0);
		issue(OP_PUSH_REAR, 32'h5, 0);
		// unused codes act as queries
		issue(3'd5, 32'hDEAD_BEEF, 0);
		issue(3'd6, 32'h0, 0);
		issue(3'd7, 32'hFFFF_FFFF, 0);
		for (int i = 0; i < DEPTH_DEF; i++)
			issue((i % 2) ? OP_POP_REAR : OP_POP_FRONT, $urandom, 0);
		issue(OP_POP_FRONT, 32'h0, 0);

		// random part: bias drifts between filling and draining
		push_pct = 50;
		run_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (run_left == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 20;
					1: push_pct = 50;
					default: push_pct = 80;
				endcase
				run_left = $urandom_range(15, 40);
			end
			run_left--;
			roll = $urandom_range(0, 99);
			if (roll < 8)
				op = OP_W'($urandom_range(4, 7));
			else if (roll < 8 + (push_pct * 92) / 100)
				op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
			else
				op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
			issue(op, pick_word(), pick_gap(i));
		end
		@(negedge clk);
		start <= 1'b0;

		while (sb.snapshots_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0)
			$display("circular_deque_top test passed");
		else
			$display("circular_deque_top test failed");
		$finish;
	end
endmodule
